// File: rtl/snps_pkg.sv
// Types, constants and helpers shared by the sorted neighbor parent select block.
package snps_pkg;

    localparam int unsigned ADDR_W = 64;
    localparam int unsigned COST_W = 16;
    localparam int unsigned RANK_W = 16;

    localparam logic [COST_W-1:0] COST_MAX    = 16'hFFFF;
    localparam logic [COST_W-1:0] COST_MIN    = 16'h0000;
    localparam logic [COST_W-1:0] SWITCH_HYST = 16'd2;
    localparam logic [COST_W-1:0] RANK_STEP   = 16'h0100;

    // One neighbor table entry.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [COST_W-1:0] cost;
        logic [RANK_W-1:0] rank;
    } entry_t;

    localparam entry_t ENTRY_NONE = '0;

    // Operation that every cell of the row performs together.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_REMOVE,
        CELL_INSERT
    } cell_op_t;

    // Command broadcast from the controller to the row of cells.
    typedef struct packed {
        cell_op_t          op;
        logic              act;
        logic [ADDR_W-1:0] addr;
        logic [COST_W-1:0] cost;
        logic [RANK_W-1:0] rank;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_CLEAR,
        ST_SELECT
    } state_t;

    function automatic logic [RANK_W-1:0] rank_of(input logic [COST_W-1:0] cost);
        if (cost > (COST_MAX - RANK_STEP)) begin
            return COST_MAX;
        end
        return cost + RANK_STEP;
    endfunction

endpackage

// File: rtl/snps_if.sv
// Valid/ready channel interfaces for neighbor items and parent results.
interface snps_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [63:0] source_address;
    logic [15:0] path_cost;
    logic [15:0] neighbor_rank;

    modport source (output valid, mode, source_address, path_cost, neighbor_rank,
                    input ready);
    modport sink   (input valid, mode, source_address, path_cost, neighbor_rank,
                    output ready);
endinterface

interface snps_out_if;
    logic        valid;
    logic        ready;
    logic        parent_update;
    logic [63:0] parent_address;
    logic [15:0] current_cost;
    logic [15:0] own_rank;

    modport source (output valid, parent_update, parent_address, current_cost, own_rank,
                    input ready);
    modport sink   (input valid, parent_update, parent_address, current_cost, own_rank,
                    output ready);
endinterface

// File: rtl/snps_cell.sv
// One neighbor table cell: holds an entry and trades it with its neighbors.
module snps_cell
    import snps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  entry_t    left_in,
    input  entry_t    right_in,
    input  logic      match_in,
    output logic      match_out,
    input  logic      ins_in,
    output logic      ins_out,
    output logic      same,
    output entry_t    entry
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   match_here;
    logic   fits;

    assign match_here = entry_reg.valid && (entry_reg.addr == cmd.addr);
    assign match_out  = match_in | match_here;
    // Only the first matching cell reports a same-cost hit.
    assign same       = match_here && !match_in && (entry_reg.cost == cmd.cost);

    assign fits    = !entry_reg.valid || (cmd.cost < entry_reg.cost);
    assign ins_out = ins_in | fits;

    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            CELL_CLEAR:
            begin
                entry_next.valid = 1'b0;
            end
            CELL_REMOVE:
            begin
                // Close the gap: everything from the match onward moves left.
                if (cmd.act && match_out) begin
                    entry_next = right_in;
                end
            end
            CELL_INSERT:
            begin
                if (ins_in) begin
                    entry_next = left_in;
                end else if (fits) begin
                    entry_next = '{valid: 1'b1, addr: cmd.addr, cost: cmd.cost,
                                   rank: cmd.rank};
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            entry_reg <= ENTRY_NONE;
        end else begin
            entry_reg <= entry_next;
        end
    end

endmodule

// File: rtl/sorted_neighbor_parent_select_top.sv
// Top level: neighbor table as a row of cells, controller and result register.
//
//  channel | dir | beat payload
//  --------+-----+-------------------------------------------------------------
//  in_ch   | in  | mode, source_address, path_cost, neighbor_rank
//  out_ch  | out | parent_update, parent_address, current_cost, own_rank
//  cfg     | in  | cfg_wr_en / cfg_wr_data -> is_root (write only)
//
// An update beat goes from accept to a loaded result through accept, remove
// pass, insert pass and select; an update that repeats a known neighbor's
// cost skips the insert pass, and an init beat goes through accept, clear
// and select. The next beat is accepted once the controller is back in idle.
// In each pass every cell hands its entry to a neighbor, with a one-bit
// prefix chain running down the row to find the position.
// Reset empties the table, clears is_root and sets the own cost to 65535.
// A stalled result holds the controller in select; input beats then wait.
module sorted_neighbor_parent_select_top
    import snps_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    snps_in_if.sink          in_ch,
    snps_out_if.source       out_ch
);

    // Controller state and the latched item.
    state_t            state_reg;
    state_t            state_next;
    logic              is_root_reg;
    logic              mode_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [COST_W-1:0] cost_reg;
    logic [RANK_W-1:0] rank_reg;
    logic              ins_reg;
    logic [COST_W-1:0] own_cost_reg;

    // Result register.
    logic              out_valid_reg;
    logic              out_upd_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [COST_W-1:0] out_cost_reg;
    logic [RANK_W-1:0] out_rank_reg;

    // Row of cells.
    cell_cmd_t              cmd;
    cell_op_t               cell_op;
    entry_t                 ent [TABLE_DEPTH];
    logic [TABLE_DEPTH:0]   match_c;
    logic [TABLE_DEPTH:0]   ins_c;
    logic [TABLE_DEPTH-1:0] same_v;
    logic [TABLE_DEPTH-1:0] valid_v;
    logic [TABLE_DEPTH-2:0] sorted_ok;

    logic              in_acc;
    logic              out_free;
    logic              load_out;
    logic              act;
    logic [COST_W-1:0] best;
    logic              hold_parent;
    logic              take_parent;
    logic [COST_W-1:0] own_cost_sel;

    assign in_acc   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign act      = !(|same_v);

    assign match_c[0] = 1'b0;
    assign ins_c[0]   = 1'b0;

    assign cmd = '{op: cell_op, act: act, addr: addr_reg, cost: cost_reg, rank: rank_reg};

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        entry_t left_e;
        entry_t right_e;

        if (i == 0) begin : g_first
            assign left_e = ENTRY_NONE;
        end else begin : g_left
            assign left_e = ent[i-1];
        end

        if (i == TABLE_DEPTH - 1) begin : g_last
            assign right_e = ENTRY_NONE;
        end else begin : g_right
            assign right_e = ent[i+1];
        end

        snps_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .left_in   (left_e),
            .right_in  (right_e),
            .match_in  (match_c[i]),
            .match_out (match_c[i+1]),
            .ins_in    (ins_c[i]),
            .ins_out   (ins_c[i+1]),
            .same      (same_v[i]),
            .entry     (ent[i])
        );

        assign valid_v[i] = ent[i].valid;
    end

    for (genvar i = 0; i < TABLE_DEPTH - 1; i++) begin : g_sorted
        assign sorted_ok[i] = !ent[i+1].valid || (ent[i].cost <= ent[i+1].cost);
    end

    // Parent choice from the head cell, with hysteresis against the own cost.
    assign best        = ent[0].cost;
    assign hold_parent = (own_cost_reg > best) && ((own_cost_reg - best) < SWITCH_HYST);
    assign take_parent = ins_reg && (!hold_parent || (best == COST_MAX));
    assign own_cost_sel = take_parent ? best : own_cost_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc) begin
                    state_next = in_ch.mode ? ST_CLEAR : ST_REMOVE;
                end
            end
            ST_REMOVE:
            begin
                state_next = act ? ST_INSERT : ST_SELECT;
            end
            ST_INSERT:
            begin
                state_next = ST_SELECT;
            end
            ST_CLEAR:
            begin
                state_next = ST_SELECT;
            end
            ST_SELECT:
            begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        in_ch.ready = 1'b0;
        cell_op     = CELL_HOLD;
        load_out    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            ST_REMOVE:
            begin
                cell_op = CELL_REMOVE;
            end
            ST_INSERT:
            begin
                cell_op = CELL_INSERT;
            end
            ST_CLEAR:
            begin
                cell_op = CELL_CLEAR;
            end
            ST_SELECT:
            begin
                load_out = out_free;
            end
            default:
            begin
                cell_op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            is_root_reg   <= 1'b0;
            own_cost_reg  <= COST_MAX;
            ins_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                is_root_reg <= cfg_wr_data;
            end
            // Track whether the insert pass placed the item; set the own cost on clear and select.
            case (state_reg)
                ST_REMOVE:
                begin
                    ins_reg <= 1'b0;
                end
                ST_INSERT:
                begin
                    ins_reg <= ins_c[TABLE_DEPTH];
                end
                ST_CLEAR:
                begin
                    ins_reg      <= 1'b0;
                    own_cost_reg <= is_root_reg ? COST_MIN : COST_MAX;
                end
                ST_SELECT:
                begin
                    if (out_free) begin
                        own_cost_reg <= own_cost_sel;
                    end
                end
                default:
                begin
                    ins_reg <= ins_reg;
                end
            endcase
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ch.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: latch the item on accept, the result on load.
    always_ff @(posedge clk)
    begin
        if (in_acc) begin
            mode_reg <= in_ch.mode;
            addr_reg <= in_ch.source_address;
            cost_reg <= in_ch.path_cost;
            rank_reg <= in_ch.neighbor_rank;
        end
        if (load_out) begin
            out_upd_reg  <= take_parent;
            out_addr_reg <= take_parent ? ent[0].addr : '0;
            out_cost_reg <= own_cost_sel;
            out_rank_reg <= rank_of(own_cost_sel);
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.parent_update  = out_upd_reg;
    assign out_ch.parent_address = out_addr_reg;
    assign out_ch.current_cost   = out_cost_reg;
    assign out_ch.own_rank       = out_rank_reg;

    // An init beat leaves the table empty once the clear pass has run.
    a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_ch.mode |=> ##1 (valid_v == '0))
        else $error("table not empty after init");

    // Valid entries always form a prefix of the row.
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_v & (valid_v + 1'b1)) == '0)
        else $error("hole in neighbor table");

    // Valid entries stay in ascending cost order.
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        &sorted_ok)
        else $error("neighbor table out of order");

    // An init beat never reports a parent.
    a_init_no_parent: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && mode_reg |-> !take_parent)
        else $error("parent set on init");

endmodule

// File: sim/sorted_neighbor_parent_select_top_test.sv
// Testbench for the neighbor-table parent selection block, self-checking against its own predictor.
module sorted_neighbor_parent_select_top_test;
    import snps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_DEPTH   = 8;
    localparam int          PHASE_COUNT   = 4;
    localparam int          PHASE_BEATS   = 490;
    localparam int          POOL_SIZE     = 12;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          LONG_HOLD     = 200;
    localparam int          PRINT_LIMIT   = 50;

    // Item mode codes on the input channel.
    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_INIT   = 1'b1;

    // One result beat as it leaves the block.
    typedef struct packed {
        logic              parent_update;
        logic [ADDR_W-1:0] parent_address;
        logic [COST_W-1:0] current_cost;
        logic [RANK_W-1:0] own_rank;
    } parent_res_t;

    typedef enum logic {
        ROW_BEAT,
        ROW_ROOT
    } row_kind_t;

    // One row of the directed table: either a beat to send or an is_root write.
    typedef struct {
        row_kind_t         kind;
        logic              root;
        logic              mode;
        logic [ADDR_W-1:0] addr;
        logic [COST_W-1:0] cost;
        logic [RANK_W-1:0] rank;
        bit                typed;
        parent_res_t       want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    snps_in_if  in_ch ();
    snps_out_if out_ch ();

    sorted_neighbor_parent_select_top #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state: the sorted neighbor table, the node's own cost and is_root.
    entry_t            nbr_table [TABLE_DEPTH];
    logic [COST_W-1:0] node_cost;
    logic              root_cfg;

    parent_res_t pending_results [$];
    int          err_count;
    bit          idle_on;
    bit          hold_off_req;

    // Directed table. Rows with typed = 1 carry an expectation that is plain from
    // the spec (reset state, init, extremes); the rest go through the predictor.
    row_t directed_rows [$] = '{
        // init right after reset: empty table, non-root cost
        '{ROW_BEAT, 1'b0, MODE_INIT, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF,
          1'b1, '{1'b0, 64'h0, 16'hFFFF, 16'hFFFF}},
        // unreachable neighbor at the head always takes the parent
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'h0, 16'hFFFF, 16'h0000,
          1'b1, '{1'b1, 64'h0, 16'hFFFF, 16'hFFFF}},
        // zero-cost neighbor jumps to the head, far below own cost
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'h1, 16'h0000, 16'hFFFF,
          1'b1, '{1'b1, 64'h1, 16'h0000, 16'h0100}},
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0001, 16'h0001,
          1'b0, '0},
        // known neighbor, same cost: nothing moves, the stored rank stays
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'h1, 16'h0000, 16'h1234, 1'b0, '0},
        // known neighbor, new cost: taken out and put back further down
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'h1, 16'h0005, 16'h0005, 1'b0, '0},
        // head one below own cost: hysteresis keeps the parent
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'h3, 16'h0000, 16'h00A5, 1'b0, '0},
        // equal cost goes behind the existing entry
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'h4, 16'h0000, 16'h005A, 1'b0, '0},
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'h5, 16'd10, 16'h8000, 1'b0, '0},
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'h6, 16'd20, 16'h7FFF, 1'b0, '0},
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'h7, 16'd30, 16'hAAAA, 1'b0, '0},
        // table full: the unreachable tail drops out
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'h8, 16'd40, 16'h5555, 1'b0, '0},
        // full table, cost equal to the tail: not inserted
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'h9, 16'd40, 16'h0001, 1'b0, '0},
        // full table, unreachable: not inserted
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'h9, 16'hFFFF, 16'h0002, 1'b0, '0},
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'hA, 16'd35, 16'h0003, 1'b0, '0},
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'hA, 16'd2, 16'h0004, 1'b0, '0},
        // head goes unreachable and moves to the tail
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'h3, 16'hFFFF, 16'h0006, 1'b0, '0},
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'h4, 16'hFFFF, 16'h0007, 1'b0, '0},
        // init on a full table
        '{ROW_BEAT, 1'b0, MODE_INIT, 64'h0, 16'h0000, 16'h0000,
          1'b1, '{1'b0, 64'h0, 16'hFFFF, 16'hFFFF}},
        '{ROW_ROOT, 1'b1, MODE_UPDATE, 64'h0, 16'h0, 16'h0, 1'b0, '0},
        // root init: own cost 0
        '{ROW_BEAT, 1'b0, MODE_INIT, 64'h8000_0000_0000_0001, 16'h8001, 16'h8001,
          1'b1, '{1'b0, 64'h0, 16'h0000, 16'h0100}},
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'h5555_5555_5555_5555, 16'h0001, 16'h1111,
          1'b0, '0},
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'hAAAA_AAAA_AAAA_AAAA, 16'hFEFF, 16'h2222,
          1'b0, '0},
        // own cost at the rank saturation edge
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'h5555_5555_5555_5555, 16'hFF00, 16'h3333,
          1'b0, '0},
        '{ROW_BEAT, 1'b0, MODE_UPDATE, 64'hAAAA_AAAA_AAAA_AAAA, 16'hFEFE, 16'h4444,
          1'b0, '0}
    };

    // Advance the predictor by one accepted beat and return the result it causes.
    function automatic parent_res_t compute_parent(
        input logic              mode,
        input logic [ADDR_W-1:0] addr,
        input logic [COST_W-1:0] cost,
        input logic [RANK_W-1:0] rank
    );
        parent_res_t       res;
        int                hit;
        bit                moved;
        bit                placed;
        logic [COST_W-1:0] best;
        res    = '0;
        hit    = -1;
        moved  = 1'b1;
        placed = 1'b0;
        if (mode == MODE_INIT)
        begin
            foreach (nbr_table[i])
            begin
                nbr_table[i] = ENTRY_NONE;
            end
            node_cost = root_cfg ? COST_MIN : COST_MAX;
        end
        else
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (hit < 0 && nbr_table[i].valid && nbr_table[i].addr == addr)
                begin
                    hit   = i;
                    moved = (nbr_table[i].cost != cost);
                end
            end
            if (moved)
            begin
                // Pull a known neighbor out, closing the gap behind it.
                if (hit >= 0)
                begin
                    for (int j = hit; j < TABLE_DEPTH - 1; j++)
                    begin
                        nbr_table[j] = nbr_table[j + 1];
                    end
                    nbr_table[TABLE_DEPTH - 1].valid = 1'b0;
                end
                // Insert after every entry of lower or equal cost; shift the rest down.
                for (int i = 0; i < TABLE_DEPTH && !placed; i++)
                begin
                    if (!nbr_table[i].valid || cost < nbr_table[i].cost)
                    begin
                        for (int j = TABLE_DEPTH - 1; j > i; j--)
                        begin
                            nbr_table[j] = nbr_table[j - 1];
                        end
                        nbr_table[i].valid = 1'b1;
                        nbr_table[i].addr  = addr;
                        nbr_table[i].cost  = cost;
                        nbr_table[i].rank  = rank;
                        placed = 1'b1;
                    end
                end
            end
            if (placed)
            begin
                best = nbr_table[0].cost;
                if (best == COST_MAX || !(node_cost > best && node_cost - best < SWITCH_HYST))
                begin
                    node_cost          = best;
                    res.parent_update  = 1'b1;
                    res.parent_address = nbr_table[0].addr;
                end
            end
        end
        res.current_cost = node_cost;
        res.own_rank     = (node_cost > COST_MAX - RANK_STEP) ? COST_MAX : node_cost + RANK_STEP;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_count < PRINT_LIMIT)
        begin
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        end
        err_count++;
    endtask

    // Offer one beat, hold it until accepted, then record what it should produce.
    task automatic send_beat(
        input logic              mode,
        input logic [ADDR_W-1:0] addr,
        input logic [COST_W-1:0] cost,
        input logic [RANK_W-1:0] rank,
        input bit                typed,
        input parent_res_t       want
    );
        parent_res_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.mode           <= mode;
        in_ch.source_address <= addr;
        in_ch.path_cost      <= cost;
        in_ch.neighbor_rank  <= rank;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        predicted = compute_parent(mode, addr, cost, rank);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Drop valid and wait until every expected result has been seen.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write is_root once the block is idle.
    task automatic write_root(input logic value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        root_cfg     = value;
    endtask

    // Receiver: ready in random runs and bursts of back-pressure, plus one long
    // hold-off on request so the block fills up and stalls its input.
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 2) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Check every accepted result beat against the oldest expectation.
    always @(posedge clk)
    begin
        parent_res_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, parent_address", out_ch.parent_address,
                                64'h0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.parent_update !== want.parent_update)
                begin
                    report_mismatch("parent_update", 64'(out_ch.parent_update),
                                    64'(want.parent_update));
                end
                if (out_ch.parent_address !== want.parent_address)
                begin
                    report_mismatch("parent_address", out_ch.parent_address,
                                    want.parent_address);
                end
                if (out_ch.current_cost !== want.current_cost)
                begin
                    report_mismatch("current_cost", 64'(out_ch.current_cost),
                                    64'(want.current_cost));
                end
                if (out_ch.own_rank !== want.own_rank)
                begin
                    report_mismatch("own_rank", 64'(out_ch.own_rank), 64'(want.own_rank));
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random phases with is_root toggled.
    initial
    begin
        logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
        logic              mode;
        logic [ADDR_W-1:0] addr;
        logic [COST_W-1:0] cost;
        int                pick;

        err_count    = 0;
        idle_on      = 1'b1;
        hold_off_req = 1'b0;
        root_cfg     = 1'b0;
        node_cost    = COST_MAX;
        foreach (nbr_table[i])
        begin
            nbr_table[i] = ENTRY_NONE;
        end

        rst_n                <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_wr_data          <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.mode           <= MODE_UPDATE;
        in_ch.source_address <= '0;
        in_ch.path_cost      <= '0;
        in_ch.neighbor_rank  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_ROOT)
            begin
                write_root(directed_rows[r].root);
            end
            else
            begin
                send_beat(directed_rows[r].mode, directed_rows[r].addr, directed_rows[r].cost,
                          directed_rows[r].rank, directed_rows[r].typed, directed_rows[r].want);
            end
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            write_root(ph[0]);
            // The last phase runs with no idling on either side.
            idle_on = (ph != PHASE_COUNT - 1);

            // Pairs of addresses that differ in one bit stress the address compare.
            for (int k = 0; k < POOL_SIZE; k++)
            begin
                if (k % 2 == 0)
                begin
                    addr_pool[k] = {$urandom, $urandom};
                end
                else
                begin
                    addr_pool[k] = addr_pool[k - 1] ^ (64'd1 << $urandom_range(0, 63));
                end
            end

            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if (ph == 1 && n == 100)
                begin
                    hold_off_req = 1'b1;
                end
                if (ph == 2 && n == 250)
                begin
                    wait_drained();
                end

                mode = (n == 0 || $urandom_range(0, 49) == 0) ? MODE_INIT : MODE_UPDATE;
                // Mostly a small set of neighbors so entries get revisited and the
                // table stays full; now and then a stranger.
                addr = ($urandom_range(0, 9) != 0) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                   : {$urandom, $urandom};
                pick = $urandom_range(0, 9);
                if (pick <= 3)
                begin
                    // Around the own cost to hit both sides of the hysteresis.
                    cost = node_cost + 16'($urandom_range(0, 6)) - 16'd3;
                end
                else if (pick <= 6)
                begin
                    cost = 16'($urandom_range(0, 40));
                end
                else if (pick == 7)
                begin
                    cost = COST_MAX;
                end
                else if (pick == 8)
                begin
                    cost = COST_MIN;
                end
                else
                begin
                    cost = 16'($urandom);
                end
                send_beat(mode, addr, cost, 16'($urandom), 1'b0, '0);
            end
        end

        wait_drained();
        if (err_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
